[design/meter_request_cycle_controller_macros.svh]
// assertion macros used by the checker file
`ifndef METER_REQUEST_CYCLE_CONTROLLER_MACROS_SVH
`define METER_REQUEST_CYCLE_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define MRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrc check failed: same-cycle rule");

// next-cycle implication, sampled on clk, idle during reset
`define MRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrc check failed: next-cycle rule");

`endif

[design/mrc_pkg.sv]
package mrc_pkg;

    // event codes
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_TICK     = 3'd1;
    localparam logic [2:0] OP_RX_BYTE  = 3'd2;
    localparam logic [2:0] OP_LINE_ERR = 3'd3;
    localparam logic [2:0] OP_TELEGRAM = 3'd4;

    // mode codes
    localparam logic [1:0] MODE_STOPPED   = 2'd0;
    localparam logic [1:0] MODE_SLEEPING  = 2'd1;
    localparam logic [1:0] MODE_RECEIVING = 2'd2;

    localparam logic [7:0] FRAME_START_CHAR = 8'h2F;
    localparam logic [5:0] CYCLE_SECONDS    = 6'd30;
    localparam logic [5:0] MINUTE_SECONDS   = 6'd60;
    localparam logic [4:0] TIMEOUT_RESET    = 5'd10;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] rx_byte;
        logic [5:0] telegram_second;
    } in_word_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       parser_reset;
        logic       request_on;
        logic       led_on;
        logic [1:0] mode_now;
    } out_word_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       frame_open;
        logic [4:0] tick_countdown;
        logic       indicator;
    } ctrl_state_t;

    // reload of a delay in seconds, in two-second ticks, kept to 5 bits
    function automatic logic [4:0] ticks_for(input logic [5:0] delay_seconds);
        logic [6:0] sum;
        sum = {1'b0, delay_seconds} + 7'd1;
        return sum[5:1];
    endfunction

endpackage

[design/mrc_step.sv]
module mrc_step
    import mrc_pkg::*;
(
    input  ctrl_state_t state,
    input  in_word_t    item,
    input  logic [4:0]  timeout,
    output ctrl_state_t state_next,
    output out_word_t   result
);

    logic [4:0] count_dec;
    logic [4:0] wake_reload;
    logic [5:0] sleep_delay;
    logic [5:0] telegram_delay;
    logic       byte_pass;
    logic       preset;

    // reloads for the three ways a countdown restarts
    always_comb
    begin
        count_dec   = (state.tick_countdown != 5'd0) ? state.tick_countdown - 5'd1 : 5'd0;
        wake_reload = ticks_for({1'b0, timeout});
        sleep_delay = ({1'b0, timeout} < CYCLE_SECONDS) ?
                      CYCLE_SECONDS - {1'b0, timeout} : 6'd0;
        if (item.telegram_second < MINUTE_SECONDS)
        begin
            telegram_delay = MINUTE_SECONDS - item.telegram_second;
            if (telegram_delay > CYCLE_SECONDS)
                telegram_delay = telegram_delay - CYCLE_SECONDS;
        end
        else
        begin
            telegram_delay = CYCLE_SECONDS;
        end
    end

    // gate check for a received byte
    assign byte_pass = (state.mode == MODE_RECEIVING) &&
                       (state.frame_open || (item.rx_byte == FRAME_START_CHAR));

    // event decode and state update
    always_comb
    begin
        state_next = state;
        preset     = 1'b0;
        case (item.opcode)
            OP_START:
            begin
                if (state.mode == MODE_STOPPED)
                begin
                    state_next.frame_open     = 1'b0;
                    state_next.indicator      = 1'b1;
                    state_next.tick_countdown = wake_reload;
                    state_next.mode           = MODE_RECEIVING;
                    preset                    = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (state.mode != MODE_STOPPED)
                begin
                    state_next.tick_countdown = count_dec;
                    if (count_dec == 5'd0)
                    begin
                        if (state.mode == MODE_SLEEPING)
                        begin
                            state_next.indicator      = 1'b1;
                            state_next.tick_countdown = wake_reload;
                            state_next.mode           = MODE_RECEIVING;
                            preset                    = 1'b1;
                        end
                        else
                        begin
                            state_next.tick_countdown = ticks_for(sleep_delay);
                            state_next.mode           = MODE_SLEEPING;
                        end
                    end
                end
            end
            OP_RX_BYTE:
            begin
                if (byte_pass)
                    state_next.frame_open = 1'b1;
            end
            OP_LINE_ERR:
            begin
                state_next.frame_open = 1'b0;
            end
            OP_TELEGRAM:
            begin
                if (state.mode == MODE_RECEIVING)
                begin
                    state_next.indicator      = 1'b0;
                    state_next.mode           = MODE_SLEEPING;
                    state_next.tick_countdown = ticks_for(telegram_delay);
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // result word
    always_comb
    begin
        result.byte_valid   = (item.opcode == OP_RX_BYTE) && byte_pass;
        result.byte_out     = result.byte_valid ? item.rx_byte : 8'd0;
        result.parser_reset = preset;
        result.request_on   = (state_next.mode == MODE_RECEIVING);
        result.led_on       = state_next.indicator;
        result.mode_now     = state_next.mode;
    end

endmodule

[design/meter_request_cycle_controller.sv]
// an accepted word enters the input register, and its result word the result register
// throughput: one word per cycle unless out_stall holds a valid result; these two registers
//   form the only pipeline, and the control state updates as a word moves between them
// reset: rst_n clears both valid flags, the mode to stopped, the gate, countdown and
//   indicator to zero, and the receive timeout to 10 seconds
module meter_request_cycle_controller
    import mrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    logic        in_valid_reg;
    logic        in_valid_next;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    out_word_t   result;
    logic [4:0]  timeout_reg;
    logic        advance;
    logic        fire;

    // pipeline flow control
    assign advance        = !out_valid_reg || !out_stall;
    assign fire           = in_valid_reg && advance;
    assign in_stall       = in_valid_reg && !advance;
    assign in_valid_next  = in_stall ? 1'b1 : in_valid;
    assign out_valid_next = fire ? 1'b1 : (out_valid_reg && out_stall);

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // event logic
    mrc_step u_step (
        .state      (state_reg),
        .item       (in_word_reg),
        .timeout    (timeout_reg),
        .state_next (state_next),
        .result     (result)
    );

    // control state, valid flags and receive timeout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg.mode           <= MODE_STOPPED;
            state_reg.frame_open     <= 1'b0;
            state_reg.tick_countdown <= 5'd0;
            state_reg.indicator      <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_data;
        if (fire)
            out_word_reg <= result;
    end

endmodule

[design/mrc_checker.sv]
`include "meter_request_cycle_controller_macros.svh"

module mrc_checker
    import mrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // request line follows the receiving mode
    `MRC_ASSERT_NOW(a_request_mode, out_valid, out_data.request_on == (out_data.mode_now == MODE_RECEIVING))

    // bytes pass only inside a receive window
    `MRC_ASSERT_NOW(a_byte_in_window, out_valid && out_data.byte_valid, out_data.request_on)

    // a window opens with the light on
    `MRC_ASSERT_NOW(a_open_led, out_valid && out_data.parser_reset, out_data.led_on && out_data.request_on)

    // a stalled result word holds
    `MRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind meter_request_cycle_controller mrc_checker u_mrc_checker (.*);
